// ===== design/idts_pkg.sv =====
// Package for the ISO duration to seconds core.
// Holds the input and result item types and the character and limit constants.
// Depends on nothing.
package idts_pkg;

	localparam int unsigned SecW = 17;

	localparam logic [SecW-1:0] LIMIT_SECONDS = 17'd86400;
	localparam logic [SecW-1:0] SEC_PER_HOUR  = 17'd3600;
	localparam logic [SecW-1:0] SEC_PER_MIN   = 17'd60;
	localparam logic [SecW-1:0] MAX_HOURS     = 17'd24;
	localparam logic [SecW-1:0] MAX_MIN_SEC   = 17'd59;

	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_M    = 8'h4D;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_final;
	} idts_in_t;

	typedef struct packed {
		logic            ok;
		logic [SecW-1:0] total_seconds;
	} idts_out_t;

endpackage

// ===== design/iso_duration_to_seconds_core.sv =====
// Top level of the ISO duration to seconds core: the whole streaming parser.
// Depends on idts_pkg for the item types and the character constants.
//
// This block parses a time-only duration text such as PT1H30M5S, taking one
// character per input item, and turns it into a count of seconds. The text
// must open with P and then T, followed by one or more decimal numbers, each
// closed by a unit letter: H (at most 24), M (at most 59) or S (at most 59).
// Units may repeat and come in any order, and the running total may not
// exceed 86400 seconds. Any bad character (a zero byte included), a number
// without a unit, a unit without digits or a limit breach makes the text
// invalid; the error is sticky until the item marked is_final. That final
// item produces exactly one result item carrying ok and total_seconds
// (total_seconds is zero when ok is zero), and the parser then starts over
// for the next text. Items that are not final produce no result. The block
// takes one item per clock cycle: each character updates the parser state
// in the same cycle it is accepted, and the result of a final character
// sits in an output register. Input is accepted whenever that output
// register is empty or is being emptied in the same cycle, so a stalled
// consumer only holds up the input once a result is waiting.
module iso_duration_to_seconds_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  idts_pkg::idts_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output idts_pkg::idts_out_t  out_data
);
	import idts_pkg::*;

	// Parser phase: waiting for P, waiting for T, or inside the body.
	typedef enum logic [1:0] {
		PH_EXPECT_P,
		PH_EXPECT_T,
		PH_BODY
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [SecW-1:0] pending_q, pending_d;
	logic            have_digits_q, have_digits_d;
	logic [SecW-1:0] total_q, total_d;
	logic            seen_q, seen_d;
	logic            failed_q, failed_d;

	logic            out_valid_q;
	idts_out_t       out_data_q;

	logic            accept;
	logic [7:0]      ch;
	logic            is_digit;
	logic            is_unit;
	logic [3:0]      digit;
	logic [19:0]     pending_ext;
	logic [SecW-1:0] unit_limit;
	logic [SecW-1:0] unit_add;
	logic [SecW:0]   total_sum;
	logic            good;

	// A result slot frees up the same cycle it is taken, so input never
	// waits on an empty or draining output register.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign ch       = in_data.text_byte;
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_unit  = (ch == CH_H) || (ch == CH_M) || (ch == CH_S);
	assign digit    = 4'(ch - CH_ZERO);

	// Next digit accumulation; the pending number is at most 86400 while the
	// text is still good, so twenty bits hold the scaled value.
	assign pending_ext = 20'(pending_q) * 20'd10 + 20'(digit);

	// Unit limit and scaled contribution. Once the limit check passes the
	// pending number fits in six bits, so only those bits feed the product.
	always_comb begin
		case (ch)
			CH_H: begin
				unit_limit = MAX_HOURS;
				unit_add   = SecW'(pending_q[5:0]) * SEC_PER_HOUR;
			end
			CH_M: begin
				unit_limit = MAX_MIN_SEC;
				unit_add   = SecW'(pending_q[5:0]) * SEC_PER_MIN;
			end
			default: begin
				unit_limit = MAX_MIN_SEC;
				unit_add   = SecW'(pending_q[5:0]);
			end
		endcase
	end

	assign total_sum = {1'b0, total_q} + {1'b0, unit_add};

	always_comb begin
		phase_d       = phase_q;
		pending_d     = pending_q;
		have_digits_d = have_digits_q;
		total_d       = total_q;
		seen_d        = seen_q;
		failed_d      = failed_q;
		if (!failed_q) begin
			case (phase_q)
				PH_EXPECT_P: begin
					if (ch == CH_P) phase_d = PH_EXPECT_T;
					else failed_d = 1'b1;
				end
				PH_EXPECT_T: begin
					if (ch == CH_T) phase_d = PH_BODY;
					else failed_d = 1'b1;
				end
				default: begin
					if (is_digit) begin
						have_digits_d = 1'b1;
						if (pending_ext > 20'(LIMIT_SECONDS)) begin
							// Saturate just above the limit and flag the text.
							pending_d = LIMIT_SECONDS + SecW'(1);
							failed_d  = 1'b1;
						end else begin
							pending_d = SecW'(pending_ext);
						end
					end else if (is_unit) begin
						if (!have_digits_q || (pending_q > unit_limit) ||
						    (total_sum > {1'b0, LIMIT_SECONDS})) begin
							failed_d = 1'b1;
						end else begin
							total_d       = SecW'(total_sum);
							seen_d        = 1'b1;
							pending_d     = '0;
							have_digits_d = 1'b0;
						end
					end else begin
						failed_d = 1'b1;
					end
				end
			endcase
		end
	end

	// The verdict on a final character uses the state after that character.
	assign good = !failed_d && (phase_d == PH_BODY) && seen_d && !have_digits_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_EXPECT_P;
			pending_q     <= '0;
			have_digits_q <= 1'b0;
			total_q       <= '0;
			seen_q        <= 1'b0;
			failed_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// A new result wins over the one being taken in the same cycle.
			if (accept && in_data.is_final) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (accept) begin
				if (in_data.is_final) begin
					// Report and start over for the next text.
					phase_q       <= PH_EXPECT_P;
					pending_q     <= '0;
					have_digits_q <= 1'b0;
					total_q       <= '0;
					seen_q        <= 1'b0;
					failed_q      <= 1'b0;
				end else begin
					phase_q       <= phase_d;
					pending_q     <= pending_d;
					have_digits_q <= have_digits_d;
					total_q       <= total_d;
					seen_q        <= seen_d;
					failed_q      <= failed_d;
				end
			end
		end
	end

	// Result payload; loaded only when a final character is taken.
	always_ff @(posedge clk) begin
		if (accept && in_data.is_final) begin
			out_data_q.ok            <= good;
			out_data_q.total_seconds <= good ? total_d : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== test/iso_duration_to_seconds_core_tb.sv =====
// Testbench for iso_duration_to_seconds_core: drives duration texts one character per item
// and checks every result item against a predictor of the parser kept in this module.
// Depends on idts_pkg and the iso_duration_to_seconds_core RTL.
module iso_duration_to_seconds_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import idts_pkg::*;

	// A run ends early if this many cycles pass with no item moving on either channel.
	localparam int unsigned STALL_LIMIT = 2000;
	// Cycles to wait after the last result, so a stray extra result would still show up.
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {
		WANT_P,
		WANT_T,
		IN_BODY
	} parse_phase_e;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	idts_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	idts_out_t out_data;

	iso_duration_to_seconds_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Parser state as the predictor sees it, updated once per accepted character.
	parse_phase_e    phase_q;
	logic [SecW-1:0] number_acc;
	logic            number_open;
	logic [SecW-1:0] seconds_sum;
	logic            unit_seen;
	logic            text_bad;

	// Results the block still owes us, oldest first.
	idts_out_t expected_durations[$];

	int unsigned error_count;
	int unsigned chars_sent;
	int unsigned quiet_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void clear_parser();
		phase_q     = WANT_P;
		number_acc  = '0;
		number_open = 1'b0;
		seconds_sum = '0;
		unit_seen   = 1'b0;
		text_bad    = 1'b0;
	endfunction

	// Apply one accepted character to the predicted parser state. On the final
	// character the expected result is queued and the parser starts over.
	function automatic void parse_char(input logic [7:0] c, input logic fin);
		int unsigned acc;
		int unsigned limit;
		int unsigned scale;
		int unsigned add;
		idts_out_t   res;
		// Once the text is bad, every character up to the final one is simply eaten.
		if (!text_bad) begin
			if (phase_q == WANT_P) begin
				if (c == CH_P) phase_q = WANT_T; else text_bad = 1'b1;
			end else if (phase_q == WANT_T) begin
				if (c == CH_T) phase_q = IN_BODY; else text_bad = 1'b1;
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				acc = number_acc * 10 + (c - CH_ZERO);
				// An oversized number is pinned just above the limit so it fits in 17 bits.
				if (acc > LIMIT_SECONDS) begin
					acc = LIMIT_SECONDS + 1;
					text_bad = 1'b1;
				end
				number_acc  = SecW'(acc);
				number_open = 1'b1;
			end else if (c == CH_H || c == CH_M || c == CH_S) begin
				if (!number_open) begin
					text_bad = 1'b1;
				end else begin
					limit = (c == CH_H) ? MAX_HOURS : MAX_MIN_SEC;
					scale = (c == CH_H) ? SEC_PER_HOUR : (c == CH_M) ? SEC_PER_MIN : 1;
					add   = number_acc * scale;
					// The limit check goes first, so add is at most a day when the sum is tested.
					if (number_acc > limit || seconds_sum > LIMIT_SECONDS - add) begin
						text_bad = 1'b1;
					end else begin
						seconds_sum = seconds_sum + SecW'(add);
						unit_seen   = 1'b1;
						number_acc  = '0;
						number_open = 1'b0;
					end
				end
			end else begin
				text_bad = 1'b1;
			end
		end
		if (fin) begin
			// A text is good only if it reached the body, closed at least one
			// component and left no number dangling without a unit.
			res.ok            = !text_bad && phase_q == IN_BODY && unit_seen && !number_open;
			res.total_seconds = res.ok ? seconds_sum : '0;
			expected_durations.push_back(res);
			clear_parser();
		end
	endfunction

	// Offer one character and hold it until the block takes it. Valid is only
	// lowered when the sender decides to idle, so back-to-back items keep it high.
	task automatic send_char(input logic [7:0] c, input logic fin);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= '{text_byte: c, is_final: fin};
		do @(posedge clk); while (!in_ready);
		parse_char(c, fin);
		chars_sent++;
	endtask

	task automatic send_text(input logic [7:0] chars[$]);
		foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
	endtask

	task automatic send_string(input string s);
		logic [7:0] chars[$];
		for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
		send_text(chars);
	endtask

	// Hand-picked texts: the largest legal hour count followed by a second that
	// pushes the total past one day, a lone zero byte, a bad second character,
	// a number with no unit, a unit with no digits, a number too large to hold
	// that also makes the parser eat the rest, and a plain good text.
	task automatic test_directed_cases();
		send_string("PT24H1S");
		send_char(8'h00, 1'b1);
		send_char(CH_P, 1'b0);
		send_char(8'hFF, 1'b1);
		send_string("PT5");
		send_string("PTS");
		send_string("PT100000S");
		send_string("PT9M59S");
	endtask

	// Most texts are well formed with random components, which is what gets the
	// parser into its body states. A share are damaged at one spot, cut short,
	// or pure noise, so the error paths and the after-failure path get exercised.
	task automatic test_random_texts(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned goal);
		int unsigned start;
		int unsigned kind;
		int unsigned val;
		int unsigned unit_pick;
		int unsigned pos;
		logic [7:0]  chars[$];
		string       digits;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = chars_sent;
		while (chars_sent - start < goal) begin
			chars.delete();
			kind = $urandom_range(99);
			if (kind < 10) begin
				repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(255)));
			end else begin
				chars.push_back(CH_P);
				chars.push_back(CH_T);
				repeat ($urandom_range(1, 4)) begin
					unit_pick = $urandom_range(2);
					// Mostly legal values, edges often, now and then far out of range.
					case ($urandom_range(9))
						0: val = $urandom_range(120000);
						1: val = (unit_pick == 0) ? MAX_HOURS : MAX_MIN_SEC;
						2: val = (unit_pick == 0) ? MAX_HOURS + 1 : MAX_MIN_SEC + 1;
						default: val = $urandom_range((unit_pick == 0) ? MAX_HOURS : MAX_MIN_SEC);
					endcase
					if ($urandom_range(7) == 0) chars.push_back(CH_ZERO);
					digits = $sformatf("%0d", val);
					for (int i = 0; i < digits.len(); i++) chars.push_back(digits[i]);
					chars.push_back((unit_pick == 0) ? CH_H : (unit_pick == 1) ? CH_M : CH_S);
				end
				if (kind < 25) begin
					pos = $urandom_range(chars.size() - 1);
					case ($urandom_range(3))
						0: chars[pos] = 8'($urandom_range(255));
						1: chars[pos] = CH_S;
						2: chars[pos] = CH_ZERO + 8'($urandom_range(9));
						default: chars[pos] = 8'h00;
					endcase
				end else if (kind < 32) begin
					void'(chars.pop_back());
				end
			end
			send_text(chars);
		end
	endtask

	// Result side: random back-pressure plus the in-order comparison.
	always @(posedge clk) begin
		idts_out_t want;
		if (out_valid && out_ready) begin
			if (expected_durations.size() == 0) begin
				$error("result with nothing expected: ok %0b total_seconds %0d",
					out_data.ok, out_data.total_seconds);
				error_count++;
			end else begin
				want = expected_durations.pop_front();
				if (out_data.ok !== want.ok) begin
					$error("ok mismatch: expected %0b, got %0b", want.ok, out_data.ok);
					error_count++;
				end
				if (out_data.total_seconds !== want.total_seconds) begin
					$error("total_seconds mismatch: expected %0d, got %0d",
						want.total_seconds, out_data.total_seconds);
					error_count++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: any cycle in which an item moves on either side resets the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		error_count    = 0;
		chars_sent     = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		clear_parser();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_ready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 14;
		recv_stall_pct = 53;
		test_directed_cases();
		// Three idling patterns: slow receiver, slow sender, then full rate.
		test_random_texts(14, 53, 380);
		test_random_texts(53, 14, 380);
		test_random_texts(0, 0, 380);
		in_valid <= 1'b0;

		while (expected_durations.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
